// File: hdl/fld_pkg.sv
// Shared types and constants for the five-channel light fader.
package fld_pkg;

  localparam int NCH   = 5;   // level, red, green, blue, temperature
  localparam int VAL_W = 16;
  localparam int CUR_W = 32;
  localparam int PTS_W = 4;
  localparam int QUO_W = 29;  // a 32-bit value divided by ten fits in 29 bits

  // Reciprocal of ten: (d * RECIP10) >> RECIP_SHIFT equals d / 10 for every 32-bit d.
  localparam logic [CUR_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NUDGE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_DIFF,
    LOP_DIV,
    LOP_APPLY,
    LOP_TICK,
    LOP_NUDGE
  } lane_op_t;

  typedef logic [NCH-1:0][VAL_W-1:0] res_t;

endpackage

// File: hdl/fld_lane.sv
// One fader channel: current value, signed step and the divide-by-ten path.
module fld_lane #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fld_pkg::lane_op_t                 op,
  input  logic [fld_pkg::VAL_W-1:0]         val,
  output logic [fld_pkg::VAL_W-1:0]         lvl
);
  import fld_pkg::*;

  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [CUR_W-1:0]   step_r, step_nxt;
  logic [CUR_W-1:0]   mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [QUO_W-1:0]   quot_r;
  logic [CUR_W-1:0]   val_fx;
  logic [2*CUR_W-1:0] prod;
  logic [CUR_W-1:0]   quot_ext;
  logic [CUR_W-1:0]   signed_step;
  logic [CUR_W-1:0]   shifted;

  assign val_fx      = {{(CUR_W-VAL_W){1'b0}}, val} << FRAC_BITS;
  assign prod        = {{CUR_W{1'b0}}, mag_r} * {{CUR_W{1'b0}}, RECIP10};
  assign quot_ext    = {{(CUR_W-QUO_W){1'b0}}, quot_r};
  assign signed_step = neg_r ? (~quot_ext + 32'd1) : quot_ext;

  always_comb begin
    cur_nxt  = cur_r;
    step_nxt = step_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    case (op)
      LOP_DIFF: begin
        neg_nxt = (val_fx < cur_r);
        mag_nxt = (val_fx < cur_r) ? (cur_r - val_fx) : (val_fx - cur_r);
      end
      LOP_APPLY: begin
        step_nxt = signed_step;
        cur_nxt  = cur_r + signed_step;
      end
      LOP_TICK:  cur_nxt = cur_r + step_r;
      LOP_NUDGE: cur_nxt = cur_r + val_fx;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      step_r <= '0;
    end else begin
      cur_r  <= cur_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    if (op == LOP_DIV) begin
      quot_r <= prod[2*CUR_W-1:RECIP_SHIFT];
    end
  end

  // The emitted level is the value after this cycle's update.
  assign shifted = cur_nxt >> FRAC_BITS;
  assign lvl     = shifted[VAL_W-1:0];

endmodule

// File: hdl/fld_outq.sv
// Two-entry result queue that gathers the lane levels into one result item.
module fld_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fld_pkg::res_t push_data,
  input  logic          out_stall,
  output logic          out_valid,
  output fld_pkg::res_t out_data,
  output logic          pop,
  output logic          full
);
  import fld_pkg::*;

  res_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign full      = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// File: hdl/five_channel_light_fader.sv
// Top level: five parallel channel lanes, fade control and the result queue.
// Tick, stop and nudge items are taken one per cycle while no start is in progress and
// the result queue is not full; a tick's result item is pushed into the queue when accepted.
// A start item holds in_stall through the divide and apply steps (difference, 32x32
// multiply by the reciprocal of ten, then apply), and its result is pushed on apply.
// Synchronous active-low reset clears the channel values, the steps and the result
// queue, and sets the point count to POINTS, so the fader comes up idle.
module five_channel_light_fader #(
  parameter int POINTS        = 10,
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_level_value,
  input  logic [15:0] in_red_value,
  input  logic [15:0] in_green_value,
  input  logic [15:0] in_blue_value,
  input  logic [15:0] in_temp_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_level_out,
  output logic [15:0] out_red_out,
  output logic [15:0] out_green_out,
  output logic [15:0] out_blue_out,
  output logic [15:0] out_temp_out
);
  import fld_pkg::*;

  // The start sequence: the item's differences are registered at acceptance, the
  // divide runs in the next cycle and the step is applied in the one after.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_APPLY
  } state_t;

  state_t               state_r, state_nxt;
  logic [PTS_W-1:0]     pts_r, pts_nxt;
  logic                 in_accept;
  action_t              act;
  lane_op_t             lane_op;
  logic                 pts_open;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  res_t                 vals;
  res_t                 lvls;
  res_t                 q_data;

  localparam logic [PTS_W-1:0] PointsC = PTS_W'(POINTS);

  assign act       = action_t'(in_action);
  assign in_stall  = (state_r != ST_RUN) || q_full;
  assign in_accept = in_valid && !in_stall;

  // A tick only steps while the fade still has points left.
  assign pts_open = (pts_r < PointsC);

  assign vals = {in_temp_value, in_blue_value, in_green_value, in_red_value, in_level_value};

  // Lane command and result push. A start produces its result only when the step
  // is applied; a tick with points left produces it in the cycle it is accepted.
  always_comb begin
    lane_op   = LOP_IDLE;
    push      = 1'b0;
    pts_nxt   = pts_r;
    state_nxt = state_r;
    case (state_r)
      ST_DIV: begin
        lane_op   = LOP_DIV;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        lane_op   = LOP_APPLY;
        push      = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (in_accept) begin
          case (act)
            ACT_START: begin
              lane_op   = LOP_DIFF;
              pts_nxt   = PTS_W'(1);
              state_nxt = ST_DIV;
            end
            ACT_TICK: begin
              if (pts_open) begin
                lane_op = LOP_TICK;
                push    = 1'b1;
                pts_nxt = pts_r + PTS_W'(1);
              end
            end
            ACT_STOP:  pts_nxt = PointsC;
            ACT_NUDGE: lane_op = LOP_NUDGE;
            default: begin
            end
          endcase
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      pts_r   <= PointsC;
    end else begin
      state_r <= state_nxt;
      pts_r   <= pts_nxt;
    end
  end

  // Each channel runs in its own lane on the same command.
  for (genvar g = 0; g < NCH; g++) begin : g_lane
    fld_lane #(
      .FRAC_BITS(FRACTION_BITS)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .op   (lane_op),
      .val  (vals[g]),
      .lvl  (lvls[g])
    );
  end

  // The queue merges the five lane levels into one result item and decouples the
  // input side from a stalled output.
  fld_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(lvls),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (q_data),
    .pop      (pop),
    .full     (q_full)
  );

  assign out_level_out = q_data[0];
  assign out_red_out   = q_data[1];
  assign out_green_out = q_data[2];
  assign out_blue_out  = q_data[3];
  assign out_temp_out  = q_data[4];

  // An accepted start always enters the divide step next.
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && act == ACT_START) |=> (state_r == ST_DIV))
    else $error("start item did not enter the divide step");

  // A result is never pushed into a full queue that is not draining.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && push && !pop))
    else $error("result queue overflow");

  // The point count never runs past the configured number of points.
  a_pts_range: assert property (@(posedge clk) disable iff (!rst_n)
    pts_r <= PointsC)
    else $error("point count beyond POINTS");

endmodule

// File: tb/fader_checker.sv
// Checker for the five-channel light fader: mirrors the fade state and compares result items.
module fader_checker #(
  parameter int POINTS        = 10,
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_level_value,
  input  logic [15:0] in_red_value,
  input  logic [15:0] in_green_value,
  input  logic [15:0] in_blue_value,
  input  logic [15:0] in_temp_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_level_out,
  input  logic [15:0] out_red_out,
  input  logic [15:0] out_green_out,
  input  logic [15:0] out_blue_out,
  input  logic [15:0] out_temp_out,
  output int          fail_count,
  output int          expected_left
);
  timeunit 1ns;
  timeprecision 1ps;
  import fld_pkg::*;

  localparam logic [CUR_W-1:0] FADE_DIV = 10;

  logic [CUR_W-1:0] chan_value [NCH];
  logic [CUR_W-1:0] chan_step  [NCH];
  logic [PTS_W-1:0] points_done;
  res_t             levels_due [$];
  string            lane_name  [NCH] = '{"level", "red", "green", "blue", "temp"};

  // Applies one accepted item to the mirrored state; returns 1 when it shows new levels.
  function automatic bit advance_fade(input action_t act, input res_t vals,
                                      output res_t shown);
    logic [CUR_W-1:0] target;
    bit               emits;
    emits = 1'b0;
    shown = '0;
    case (act)
      ACT_START: begin
        for (int c = 0; c < NCH; c++) begin
          target = CUR_W'(vals[c]) << FRACTION_BITS;
          if (target < chan_value[c]) begin
            chan_step[c] = '0 - ((chan_value[c] - target) / FADE_DIV);
          end else begin
            chan_step[c] = (target - chan_value[c]) / FADE_DIV;
          end
          chan_value[c] = chan_value[c] + chan_step[c];
        end
        points_done = PTS_W'(1);
        emits = 1'b1;
      end
      ACT_TICK: begin
        if (points_done < POINTS) begin
          points_done = points_done + 1'b1;
          for (int c = 0; c < NCH; c++) chan_value[c] = chan_value[c] + chan_step[c];
          emits = 1'b1;
        end
      end
      ACT_STOP: begin
        points_done = PTS_W'(POINTS);
      end
      default: begin
        for (int c = 0; c < NCH; c++) begin
          chan_value[c] = chan_value[c] + (CUR_W'(vals[c]) << FRACTION_BITS);
        end
      end
    endcase
    if (emits) begin
      for (int c = 0; c < NCH; c++) shown[c] = VAL_W'(chan_value[c] >> FRACTION_BITS);
    end
    return emits;
  endfunction

  always @(posedge clk) begin
    res_t seen;
    res_t due;
    res_t shown;
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        chan_value[c] = '0;
        chan_step[c]  = '0;
      end
      points_done = PTS_W'(POINTS);
      levels_due.delete();
    end else begin
      // A result can never stem from an item accepted at the same edge, so the
      // output side is checked before the input side adds to the queue.
      if (out_valid && !out_stall) begin
        seen = {out_temp_out, out_blue_out, out_green_out, out_red_out, out_level_out};
        if (levels_due.size() == 0) begin
          $display("%0t: result item with none expected: %h", $time, seen);
          fail_count++;
        end else begin
          due = levels_due.pop_front();
          for (int c = 0; c < NCH; c++) begin
            if (seen[c] !== due[c]) begin
              $display("%0t: %s expected %h, got %h", $time, lane_name[c], due[c], seen[c]);
              fail_count++;
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (advance_fade(action_t'(in_action),
                         {in_temp_value, in_blue_value, in_green_value, in_red_value,
                          in_level_value}, shown)) begin
          levels_due.push_back(shown);
        end
      end
    end
    expected_left = levels_due.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the light fader testbench: clock, reset, stimulus, flow control and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fld_pkg::*;

  localparam int FADE_POINTS   = 10;
  localparam int FADE_FRAC     = 8;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int SETTLE_CYCLES = 10;

  typedef logic [NCH-1:0][VAL_W-1:0] chan_vals_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [15:0] in_level_value;
  logic [15:0] in_red_value;
  logic [15:0] in_green_value;
  logic [15:0] in_blue_value;
  logic [15:0] in_temp_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_level_out;
  logic [15:0] out_red_out;
  logic [15:0] out_green_out;
  logic [15:0] out_blue_out;
  logic [15:0] out_temp_out;

  int fail_count;
  int expected_left;

  // Stimulus bookkeeping: every accepted item counts toward the item budget.
  int sent_items;
  bit steady_tx;
  int quiet_cycles;

  five_channel_light_fader #(
    .POINTS       (FADE_POINTS),
    .FRACTION_BITS(FADE_FRAC)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_level_value(in_level_value),
    .in_red_value  (in_red_value),
    .in_green_value(in_green_value),
    .in_blue_value (in_blue_value),
    .in_temp_value (in_temp_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_level_out (out_level_out),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_temp_out  (out_temp_out)
  );

  fader_checker #(
    .POINTS       (FADE_POINTS),
    .FRACTION_BITS(FADE_FRAC)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_level_value(in_level_value),
    .in_red_value  (in_red_value),
    .in_green_value(in_green_value),
    .in_blue_value (in_blue_value),
    .in_temp_value (in_temp_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_level_out (out_level_out),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_temp_out  (out_temp_out),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // 12 ns period clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A channel value is the all-zero or the all-one pattern about one time in
  // ten each, so the extremes keep showing up among the random items.
  function automatic logic [15:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'h0000;
    if (roll < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic chan_vals_t pick_vals();
    chan_vals_t vals;
    for (int c = 0; c < NCH; c++) vals[c] = pick_level();
    return vals;
  endfunction

  // Offers one item, starting and ending on a falling edge, and returns once
  // the block has accepted it. Before the item the sender may sit idle, unless
  // a steady stretch is in progress. Valid is only ever assigned once per
  // falling edge, so back-to-back items keep it high.
  task automatic send(input action_t act, input chan_vals_t vals);
    if (!steady_tx && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_level_value <= vals[0];
    in_red_value   <= vals[1];
    in_green_value <= vals[2];
    in_blue_value  <= vals[3];
    in_temp_value  <= vals[4];
    // The stall seen at the rising edge is the value from before that edge,
    // so leaving the loop means the item went in at that edge.
    do @(posedge clk); while (in_stall);
    sent_items++;
    @(negedge clk);
  endtask

  // Result side flow control. Cycles are counted from the end of reset. One
  // long hold-off lets the result queue fill so the block has to stall its
  // input, and one long stretch takes every result the moment it appears.
  // Elsewhere the receiver stalls about a third of the time.
  initial begin
    int rx_cycle;
    rx_cycle  = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 400 && rx_cycle < 550) begin
        out_stall <= 1'b1;
      end else if (rx_cycle >= 1200 && rx_cycle < 1600) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 33);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_MAX);
        $display("[five_channel_light_fader] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int n_ticks;
    int roll;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_TICK;
    in_level_value = '0;
    in_red_value   = '0;
    in_green_value = '0;
    in_blue_value  = '0;
    in_temp_value  = '0;
    sent_items     = 0;
    steady_tx      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The fader comes up idle, so a tick and a stop right after
    // reset must both stay silent.
    send(ACT_TICK, {5{16'hFFFF}});
    send(ACT_STOP, '0);
    // Fade up from zero to full scale on every channel, then a few steps.
    send(ACT_START, {5{16'hFFFF}});
    repeat (3) send(ACT_TICK, '0);
    // Nudge by the largest offset; this emits nothing but moves every channel.
    send(ACT_NUDGE, {5{16'hFFFF}});
    // Fade back down to zero, which needs negative steps, then stop it early.
    // The tick after the stop must not produce anything.
    send(ACT_START, '0);
    repeat (2) send(ACT_TICK, '0);
    send(ACT_STOP, {5{16'hFFFF}});
    send(ACT_TICK, '0);
    // Mixed targets, some above and some below the current values, and green
    // and blue differ so a swap between them would show. Running past the
    // point count checks that the fade ends on its own.
    send(ACT_START, {16'h5555, 16'hAAAA, 16'h1234, 16'hFFFF, 16'h0000});
    repeat (FADE_POINTS + 1) send(ACT_TICK, {5{16'h8001}});

    // Random part. Mostly whole fades: a start with random targets followed by
    // a run of ticks, sometimes longer than the fade, with an occasional nudge
    // or stop dropped in. The rest is loose noise of any action.
    while (sent_items < RANDOM_ITEMS) begin
      steady_tx = (sent_items >= 700 && sent_items < 900);
      if ($urandom_range(99) < 80) begin
        send(ACT_START, pick_vals());
        n_ticks = $urandom_range(FADE_POINTS + 2, 1);
        for (int k = 0; k < n_ticks; k++) begin
          roll = $urandom_range(99);
          if (roll < 6) begin
            send(ACT_NUDGE, pick_vals());
          end else if (roll < 10) begin
            send(ACT_STOP, pick_vals());
          end else begin
            send(ACT_TICK, pick_vals());
          end
        end
      end else begin
        repeat ($urandom_range(4, 1)) send(action_t'($urandom_range(3)), pick_vals());
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then hold on through a settling wait
    // so a stray result can show up. The watchdog bounds the wait.
    wait (expected_left == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[five_channel_light_fader] OK");
    end else begin
      $display("[five_channel_light_fader] ERROR");
    end
    $finish;
  end

endmodule
